[rtl/core/bscu_pkg.sv]
// ----------------------------------------------------------------------------
// bscu_pkg
// Shared types, codes and character maps for the Base64 stream codec.
// ----------------------------------------------------------------------------
package bscu_pkg;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [7:0] C_PAD   = 8'h3d;
    localparam logic [7:0] C_PLUS  = 8'h2b;
    localparam logic [7:0] C_SLASH = 8'h2f;

    // One finished group handed from the front to the back.
    // cnt: encode -> bytes held (1..3); decode -> bytes to emit (1..3).
    typedef struct packed {
        logic        mode;
        logic [23:0] bits;
        logic [1:0]  cnt;
        logic        last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26)      return 8'h41 + w;
        else if (w < 8'd52) return 8'h61 + (w - 8'd26);
        else if (w < 8'd62) return 8'h30 + (w - 8'd52);
        else if (w == 8'd62) return C_PLUS;
        else                return C_SLASH;
    endfunction

    function automatic logic [5:0] dec_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5a)      t = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7a) t = c - 8'h61 + 8'd26;
        else if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30 + 8'd52;
        else if (c == C_PLUS)              t = 8'd62;
        else if (c == C_SLASH)             t = 8'd63;
        return t[5:0];
    endfunction

endpackage

[rtl/core/bscu_front.sv]
// ----------------------------------------------------------------------------
// bscu_front
// Gathers input words into 24-bit groups and issues finished groups as jobs.
// ----------------------------------------------------------------------------
module bscu_front import bscu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  t_q_stat     i_q_stat,
    output logic        o_ready,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_mode;
    logic [23:0] r_bits;
    logic [1:0]  r_cnt;
    logic [1:0]  r_pad;

    logic        accept;
    logic [23:0] enc_bits;
    logic [23:0] dec_bits;
    logic [5:0]  dval;
    logic [1:0]  npad;
    logic        enc_done;
    logic        dec_done;

    assign o_ready = ~i_q_stat.full;
    assign accept  = i_valid & o_ready;
    assign dval    = dec_value(i_byte);

    always_comb begin
        case (r_cnt)
            2'd0:    enc_bits = r_bits | {i_byte, 16'h0000};
            2'd1:    enc_bits = r_bits | {8'h00, i_byte, 8'h00};
            default: enc_bits = r_bits | {16'h0000, i_byte};
        endcase
        case (r_cnt)
            2'd0:    dec_bits = r_bits | {dval, 18'h0};
            2'd1:    dec_bits = r_bits | {6'h0, dval, 12'h0};
            2'd2:    dec_bits = r_bits | {12'h0, dval, 6'h0};
            default: dec_bits = r_bits | {18'h0, dval};
        endcase
    end

    assign npad     = r_pad + {1'b0, (i_byte == C_PAD) && r_cnt[1]};
    assign enc_done = (r_cnt == 2'd2) | i_last;
    assign dec_done = (r_cnt == 2'd3);

    always_comb begin
        o_job.mode = r_mode;
        o_job.last = i_last;
        if (r_mode == MODE_ENC) begin
            o_job.bits = enc_bits;
            o_job.cnt  = r_cnt + 2'd1;
            o_push     = accept & enc_done;
        end else begin
            o_job.bits = dec_bits;
            o_job.cnt  = i_last ? 2'd3 - npad : 2'd3;
            o_push     = accept & dec_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
            r_bits <= '0;
            r_cnt  <= '0;
            r_pad  <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
            r_bits <= '0;
            r_cnt  <= '0;
            r_pad  <= '0;
        end else if (accept) begin
            if (r_mode == MODE_ENC) begin
                if (enc_done) begin
                    r_bits <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_bits <= enc_bits;
                    r_cnt  <= r_cnt + 2'd1;
                end
                r_pad <= '0;
            end else begin
                if (dec_done || i_last) begin
                    r_bits <= '0;
                    r_cnt  <= '0;
                    r_pad  <= '0;
                end else begin
                    r_bits <= dec_bits;
                    r_cnt  <= r_cnt + 2'd1;
                    r_pad  <= npad;
                end
            end
        end
    end

endmodule

[rtl/core/bscu_queue.sv]
// ----------------------------------------------------------------------------
// bscu_queue
// Two-entry job queue between the group front and the output back.
// ----------------------------------------------------------------------------
module bscu_queue import bscu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic       do_push;
    logic       do_pop;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_job        = r_mem[r_rd];
    assign do_push      = i_push & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[rtl/core/bscu_back.sv]
// ----------------------------------------------------------------------------
// bscu_back
// Serializes each job to characters or bytes, one output word per ready cycle.
// ----------------------------------------------------------------------------
module bscu_back import bscu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    input  logic       i_tready,
    output logic       o_tvalid,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;

    logic       load;
    logic [1:0] last_idx;
    logic       at_end;
    logic [5:0] sext;
    logic [7:0] n_data;

    assign load     = ~i_q_stat.empty & (~r_valid | i_tready);
    assign last_idx = (i_job.mode == MODE_ENC) ? 2'd3 : i_job.cnt - 2'd1;
    assign at_end   = (r_idx == last_idx);
    assign o_pop    = load & at_end;

    always_comb begin
        case (r_idx)
            2'd0:    sext = i_job.bits[23:18];
            2'd1:    sext = i_job.bits[17:12];
            2'd2:    sext = i_job.bits[11:6];
            default: sext = i_job.bits[5:0];
        endcase
        if (i_job.mode == MODE_ENC) begin
            n_data = (r_idx > i_job.cnt) ? C_PAD : enc_char(sext);
        end else begin
            case (r_idx)
                2'd0:    n_data = i_job.bits[23:16];
                2'd1:    n_data = i_job.bits[15:8];
                default: n_data = i_job.bits[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
            r_last <= i_job.last & at_end;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

[rtl/core/base64_stream_codec_unit.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Streaming Base64 encoder/decoder selected by a one-bit mode register.
// ----------------------------------------------------------------------------
// Each finished group is queued, and its first output word is then registered.
// Throughput: input takes one word per cycle while the 2-entry job queue has
// room; the output port emits one word per cycle while the sink is ready;
// encode maps 3 input words to 4 output words, decode 4 input words to 3.
// Reset (i_rst_n low, synchronous): mode = encode, group and queue cleared.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit import bscu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);

    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    bscu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_q_stat    (q_stat),
        .o_ready     (o_s_axis_tready),
        .o_push      (push),
        .o_job       (push_job)
    );

    bscu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    bscu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
